[hdl/smec_pkg.sv]
// Shared constants, codes and types of the stack machine execute core.
package smec_pkg;

  localparam int unsigned StackDepth = 256;
  localparam int unsigned AddrW      = 8;
  localparam int unsigned SpW        = 9;
  localparam int unsigned WordW      = 64;
  localparam int unsigned PtrW       = 32;
  localparam int unsigned MulChunk   = 16;
  localparam int unsigned CntW       = 6;

  typedef enum logic [4:0] {
    OP_ADD   = 5'd0,
    OP_SUB   = 5'd1,
    OP_MUL   = 5'd2,
    OP_DIV   = 5'd3,
    OP_MOD   = 5'd4,
    OP_SHL   = 5'd5,
    OP_SHR   = 5'd6,
    OP_CMP   = 5'd7,
    OP_SKIPZ = 5'd8,
    OP_IP    = 5'd9,
    OP_FP    = 5'd10,
    OP_JUMP  = 5'd11,
    OP_PUSH  = 5'd12,
    OP_PUSHW = 5'd13,
    OP_DUP   = 5'd14,
    OP_POP   = 5'd15,
    OP_SWAP  = 5'd16,
    OP_ENTER = 5'd17,
    OP_LEAVE = 5'd18,
    OP_IN    = 5'd19,
    OP_OUT   = 5'd20,
    OP_ALLOC = 5'd21,
    OP_LOAD  = 5'd22,
    OP_STORE = 5'd23,
    OP_NCALL = 5'd24,
    OP_NOP   = 5'd25
  } op_e;

  typedef enum logic [2:0] {
    ERR_OK          = 3'd0,
    ERR_UNDERFLOW   = 3'd1,
    ERR_OVERFLOW    = 3'd2,
    ERR_DIV_ZERO    = 3'd3,
    ERR_UNSUPPORTED = 3'd4
  } err_e;

  typedef enum logic [1:0] {
    MDU_MUL = 2'd0,
    MDU_DIV = 2'd1,
    MDU_MOD = 2'd2
  } mdu_op_e;

  typedef struct packed {
    logic accept;
    logic exec;
    logic commit_mdu;
    logic wr2;
  } cmd_t;

  typedef struct packed {
    logic pre_stop;
    logic need_mdu;
    logic need_wr2;
    logic mdu_done;
  } sts_t;

  function automatic logic [1:0] op_need(logic [4:0] op);
    logic [1:0] n;
    n = 2'd0;
    case (op)
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_SHL, OP_SHR, OP_CMP,
      OP_SWAP, OP_LEAVE:                          n = 2'd2;
      OP_SKIPZ, OP_JUMP, OP_DUP, OP_POP, OP_OUT:  n = 2'd1;
      default:                                    n = 2'd0;
    endcase
    return n;
  endfunction

  function automatic logic [1:0] op_grow(logic [4:0] op);
    logic [1:0] g;
    g = 2'd0;
    case (op)
      OP_IP, OP_FP, OP_PUSH, OP_PUSHW, OP_DUP, OP_IN: g = 2'd1;
      OP_ENTER:                                       g = 2'd2;
      default:                                        g = 2'd0;
    endcase
    return g;
  endfunction

endpackage

[hdl/smec_if.sv]
// Instruction and result channel interfaces of the stack machine execute core.
interface smec_in_if;
  logic               valid;
  logic               ready;
  logic [4:0]         opcode;
  logic signed [63:0] immediate;
  logic [31:0]        next_address;
  logic signed [7:0]  console_in;

  modport source (output valid, opcode, immediate, next_address, console_in, input ready);
  modport sink   (input valid, opcode, immediate, next_address, console_in, output ready);
endinterface

interface smec_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] top_value;
  logic [8:0]         stack_depth;
  logic               jump_taken;
  logic [31:0]        jump_target;
  logic               skip_next;
  logic               out_valid;
  logic [7:0]         out_byte;
  logic               halted;
  logic [2:0]         error_code;

  modport source (output valid, top_value, stack_depth, jump_taken, jump_target, skip_next,
                  out_valid, out_byte, halted, error_code, input ready);
  modport sink   (input valid, top_value, stack_depth, jump_taken, jump_target, skip_next,
                  out_valid, out_byte, halted, error_code, output ready);
endinterface

[hdl/smec_mdu.sv]
// Iterative multiply and signed divide/modulo unit.
module smec_mdu (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  smec_pkg::mdu_op_e            kind_i,
  input  logic [smec_pkg::WordW-1:0]   a_i,
  input  logic [smec_pkg::WordW-1:0]   b_i,
  output logic                         done_o,
  output logic [smec_pkg::WordW-1:0]   res_o
);

  logic                         busy_q;
  logic                         done_q;
  smec_pkg::mdu_op_e            kind_q;
  logic [smec_pkg::CntW-1:0]    cnt_q;
  logic [smec_pkg::WordW-1:0]   acc_q;
  logic [smec_pkg::WordW-1:0]   quo_q;
  logic [smec_pkg::WordW-1:0]   opa_q;
  logic                         neg_q;

  logic [smec_pkg::WordW-1:0]   mag_a;
  logic [smec_pkg::WordW-1:0]   mag_b;
  logic [smec_pkg::WordW-1:0]   rem_sh;
  logic                         fits;
  logic [smec_pkg::WordW-1:0]   pp;

  assign mag_a  = a_i[smec_pkg::WordW-1] ? (~a_i + 1'b1) : a_i;
  assign mag_b  = b_i[smec_pkg::WordW-1] ? (~b_i + 1'b1) : b_i;
  assign rem_sh = {acc_q[smec_pkg::WordW-2:0], quo_q[smec_pkg::WordW-1]};
  assign fits   = rem_sh >= opa_q;
  assign pp     = smec_pkg::WordW'(opa_q * quo_q[smec_pkg::MulChunk-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && (cnt_q == '0);
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && (cnt_q == '0)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      kind_q <= kind_i;
      acc_q  <= '0;
      if (kind_i == smec_pkg::MDU_MUL) begin
        cnt_q <= smec_pkg::CntW'(smec_pkg::WordW / smec_pkg::MulChunk - 1);
        opa_q <= a_i;
        quo_q <= b_i;
        neg_q <= 1'b0;
      end else begin
        cnt_q <= smec_pkg::CntW'(smec_pkg::WordW - 1);
        opa_q <= mag_b;
        quo_q <= mag_a;
        neg_q <= (kind_i == smec_pkg::MDU_DIV) ?
                 (a_i[smec_pkg::WordW-1] ^ b_i[smec_pkg::WordW-1]) : a_i[smec_pkg::WordW-1];
      end
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (kind_q == smec_pkg::MDU_MUL) begin
        acc_q <= acc_q + pp;
        opa_q <= opa_q << smec_pkg::MulChunk;
        quo_q <= quo_q >> smec_pkg::MulChunk;
      end else begin
        acc_q <= fits ? (rem_sh - opa_q) : rem_sh;
        quo_q <= {quo_q[smec_pkg::WordW-2:0], fits};
      end
    end
  end

  always_comb begin
    unique case (kind_q)
      smec_pkg::MDU_MUL: res_o = acc_q;
      smec_pkg::MDU_DIV: res_o = neg_q ? (~quo_q + 1'b1) : quo_q;
      default:           res_o = neg_q ? (~acc_q + 1'b1) : acc_q;
    endcase
  end

  assign done_o = done_q;

endmodule

[hdl/smec_ctrl.sv]
// Sequencing state machine of the stack machine execute core.
module smec_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  smec_pkg::sts_t  sts_i,
  output smec_pkg::cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_WAIT,
    S_WR2,
    S_OUT
  } state_e;

  state_e state_q;
  logic   out_vld_q;

  assign in_ready_o       = (state_q == S_IDLE);
  assign out_valid_o      = out_vld_q;
  assign cmd_o.accept     = (state_q == S_IDLE) && in_valid_i;
  assign cmd_o.exec       = (state_q == S_EXEC);
  assign cmd_o.commit_mdu = (state_q == S_WAIT) && sts_i.mdu_done;
  assign cmd_o.wr2        = (state_q == S_WR2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            if (sts_i.pre_stop) begin
              state_q   <= S_OUT;
              out_vld_q <= 1'b1;
            end else begin
              state_q <= S_EXEC;
            end
          end
        end
        S_EXEC: begin
          priority if (sts_i.need_mdu) begin
            state_q <= S_WAIT;
          end else if (sts_i.need_wr2) begin
            state_q <= S_WR2;
          end else begin
            state_q   <= S_OUT;
            out_vld_q <= 1'b1;
          end
        end
        S_WAIT: begin
          if (sts_i.mdu_done) begin
            state_q   <= S_OUT;
            out_vld_q <= 1'b1;
          end
        end
        S_WR2: begin
          state_q   <= S_OUT;
          out_vld_q <= 1'b1;
        end
        S_OUT: begin
          if (out_ready_i) begin
            state_q   <= S_IDLE;
            out_vld_q <= 1'b0;
          end
        end
        default: begin
          state_q   <= S_IDLE;
          out_vld_q <= 1'b0;
        end
      endcase
    end
  end

endmodule

[hdl/smec_dp.sv]
// Datapath: stack memory, pointers, ALU and result registers.
module smec_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [smec_pkg::SpW-1:0]      cfg_wdata_i,
  input  logic [4:0]                    opcode_i,
  input  logic [smec_pkg::WordW-1:0]    immediate_i,
  input  logic [smec_pkg::PtrW-1:0]     next_address_i,
  input  logic [7:0]                    console_in_i,
  input  smec_pkg::cmd_t                cmd_i,
  output smec_pkg::sts_t                sts_o,
  output logic [smec_pkg::WordW-1:0]    top_value_o,
  output logic [smec_pkg::SpW-1:0]      stack_depth_o,
  output logic                          jump_taken_o,
  output logic [smec_pkg::PtrW-1:0]     jump_target_o,
  output logic                          skip_next_o,
  output logic                          out_valid_o,
  output logic [7:0]                    out_byte_o,
  output logic                          halted_o,
  output logic [2:0]                    error_code_o
);

  localparam int unsigned W  = smec_pkg::WordW;
  localparam int unsigned AW = smec_pkg::AddrW;
  localparam int unsigned SW = smec_pkg::SpW;
  localparam int unsigned PW = smec_pkg::PtrW;

  logic [W-1:0] mem [smec_pkg::StackDepth];

  logic [SW-1:0]    sp_q, sp_d, lim_q, cap;
  logic [PW-1:0]    fp_q, fp_d;
  logic [W-1:0]     top_q, top_d;
  logic             halt_q, halt_d;
  logic             jt_q, jt_d, skip_q, skip_d, ov_q, ov_d;
  logic [PW-1:0]    jtg_q, jtg_d;
  logic [7:0]       ob_q, ob_d;
  smec_pkg::err_e   err_q, err_d, pre_err;

  smec_pkg::op_e    op_q;
  logic [W-1:0]     imm_q, w2_q, w2_d, rda_q, rdc_q;
  logic [PW-1:0]    nxt_q;
  logic [7:0]       cin_q;

  logic [W-1:0]     a, b, c, r, mdu_res, push_v;
  logic [5:0]       shr_n;
  logic             we, mdu_start, mdu_done, unsup;
  logic [AW-1:0]    wa;
  logic [W-1:0]     wd;
  smec_pkg::mdu_op_e mdu_kind;
  logic [1:0]       need, grow;

  assign cap   = (lim_q < SW'(smec_pkg::StackDepth)) ? lim_q : SW'(smec_pkg::StackDepth);
  assign need  = smec_pkg::op_need(opcode_i);
  assign grow  = smec_pkg::op_grow(opcode_i);
  assign unsup = (opcode_i > smec_pkg::OP_NOP) ||
                 ((opcode_i >= smec_pkg::OP_ALLOC) && (opcode_i <= smec_pkg::OP_NCALL));

  always_comb begin
    priority if (halt_q) begin
      pre_err = smec_pkg::ERR_OK;
    end else if (unsup) begin
      pre_err = smec_pkg::ERR_UNSUPPORTED;
    end else if (SW'(need) > sp_q) begin
      pre_err = smec_pkg::ERR_UNDERFLOW;
    end else if (({1'b0, sp_q} + (SW + 1)'(grow)) > {1'b0, cap}) begin
      pre_err = smec_pkg::ERR_OVERFLOW;
    end else begin
      pre_err = smec_pkg::ERR_OK;
    end
  end

  assign a = (sp_q >= SW'(2)) ? rda_q : '0;
  assign c = (sp_q >= SW'(3)) ? rdc_q : '0;
  assign b = top_q;

  assign shr_n = (|b[W-1:6]) ? 6'd63 : b[5:0];

  always_comb begin
    unique case (op_q)
      smec_pkg::OP_ADD: r = a + b;
      smec_pkg::OP_SUB: r = a - b;
      smec_pkg::OP_SHL: r = (|b[W-1:6]) ? '0 : (a << b[5:0]);
      smec_pkg::OP_SHR: r = W'($signed(a) >>> shr_n);
      smec_pkg::OP_CMP: r = ($signed(a) < $signed(b)) ? '1 :
                            (($signed(a) > $signed(b)) ? W'(1) : '0);
      default:          r = '0;
    endcase
  end

  always_comb begin
    unique case (op_q)
      smec_pkg::OP_IP:  push_v = W'(nxt_q);
      smec_pkg::OP_FP:  push_v = W'(fp_q);
      smec_pkg::OP_DUP: push_v = b;
      smec_pkg::OP_IN:  push_v = {{(W-8){cin_q[7]}}, cin_q};
      default:          push_v = imm_q;
    endcase
  end

  always_comb begin
    unique case (op_q)
      smec_pkg::OP_DIV: mdu_kind = smec_pkg::MDU_DIV;
      smec_pkg::OP_MOD: mdu_kind = smec_pkg::MDU_MOD;
      default:          mdu_kind = smec_pkg::MDU_MUL;
    endcase
  end

  assign sts_o.pre_stop = halt_q || (pre_err != smec_pkg::ERR_OK);
  assign sts_o.need_mdu = (op_q == smec_pkg::OP_MUL) ||
                          (((op_q == smec_pkg::OP_DIV) || (op_q == smec_pkg::OP_MOD)) && (b != '0));
  assign sts_o.need_wr2 = (op_q == smec_pkg::OP_SWAP) || (op_q == smec_pkg::OP_ENTER);
  assign sts_o.mdu_done = mdu_done;

  always_comb begin
    sp_d = sp_q; fp_d = fp_q; top_d = top_q; halt_d = halt_q;
    jt_d = jt_q; jtg_d = jtg_q; skip_d = skip_q; ov_d = ov_q; ob_d = ob_q; err_d = err_q;
    w2_d = w2_q; we = 1'b0; wa = AW'(sp_q); wd = '0; mdu_start = 1'b0;
    priority if (cmd_i.accept) begin
      jt_d = 1'b0; jtg_d = '0; skip_d = 1'b0; ov_d = 1'b0; ob_d = '0;
      err_d = pre_err;
    end else if (cmd_i.exec) begin
      unique case (op_q)
        smec_pkg::OP_ADD, smec_pkg::OP_SUB, smec_pkg::OP_SHL, smec_pkg::OP_SHR,
        smec_pkg::OP_CMP: begin
          we = 1'b1; wa = AW'(sp_q - SW'(2)); wd = r;
          sp_d = sp_q - SW'(1); top_d = r;
        end
        smec_pkg::OP_MUL: mdu_start = 1'b1;
        smec_pkg::OP_DIV, smec_pkg::OP_MOD: begin
          if (b == '0) begin
            err_d = smec_pkg::ERR_DIV_ZERO;
          end else begin
            mdu_start = 1'b1;
          end
        end
        smec_pkg::OP_SKIPZ: skip_d = (b == '0);
        smec_pkg::OP_IP, smec_pkg::OP_FP, smec_pkg::OP_PUSH, smec_pkg::OP_PUSHW,
        smec_pkg::OP_DUP, smec_pkg::OP_IN: begin
          we = 1'b1; wa = AW'(sp_q); wd = push_v;
          sp_d = sp_q + SW'(1); top_d = push_v;
        end
        smec_pkg::OP_JUMP: begin
          sp_d = sp_q - SW'(1); top_d = a;
          if (b == '0) begin
            halt_d = 1'b1;
          end else begin
            jt_d = 1'b1; jtg_d = b[PW-1:0];
          end
        end
        smec_pkg::OP_POP: begin
          sp_d = sp_q - SW'(1); top_d = a;
        end
        smec_pkg::OP_OUT: begin
          sp_d = sp_q - SW'(1); top_d = a; ov_d = 1'b1; ob_d = b[7:0];
        end
        smec_pkg::OP_SWAP: begin
          we = 1'b1; wa = AW'(sp_q - SW'(2)); wd = b;
          top_d = a; w2_d = a;
        end
        smec_pkg::OP_ENTER: begin
          we = 1'b1; wa = AW'(sp_q); wd = W'(fp_q);
          fp_d = PW'(sp_q); sp_d = sp_q + SW'(2); top_d = '0; w2_d = '0;
        end
        smec_pkg::OP_LEAVE: begin
          fp_d = a[PW-1:0]; sp_d = sp_q - SW'(2); top_d = c;
        end
        default: begin
        end
      endcase
    end else if (cmd_i.commit_mdu) begin
      we = 1'b1; wa = AW'(sp_q - SW'(2)); wd = mdu_res;
      sp_d = sp_q - SW'(1); top_d = mdu_res;
    end else if (cmd_i.wr2) begin
      we = 1'b1; wa = AW'(sp_q - SW'(1)); wd = w2_q;
    end
  end

  smec_mdu u_mdu (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mdu_start),
    .kind_i  (mdu_kind),
    .a_i     (a),
    .b_i     (b),
    .done_o  (mdu_done),
    .res_o   (mdu_res)
  );

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (cmd_i.accept) begin
      rda_q <= mem[AW'(sp_q - SW'(2))];
      rdc_q <= mem[AW'(sp_q - SW'(3))];
      op_q  <= smec_pkg::op_e'(opcode_i);
      imm_q <= immediate_i;
      nxt_q <= next_address_i;
      cin_q <= console_in_i;
    end
    w2_q <= w2_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q   <= '0;
      fp_q   <= '0;
      top_q  <= '0;
      halt_q <= 1'b0;
      lim_q  <= SW'(smec_pkg::StackDepth);
      jt_q   <= 1'b0;
      jtg_q  <= '0;
      skip_q <= 1'b0;
      ov_q   <= 1'b0;
      ob_q   <= '0;
      err_q  <= smec_pkg::ERR_OK;
    end else begin
      sp_q   <= sp_d;
      fp_q   <= fp_d;
      top_q  <= top_d;
      halt_q <= halt_d;
      jt_q   <= jt_d;
      jtg_q  <= jtg_d;
      skip_q <= skip_d;
      ov_q   <= ov_d;
      ob_q   <= ob_d;
      err_q  <= err_d;
      if (cfg_we_i) begin
        lim_q <= cfg_wdata_i;
      end
    end
  end

  assign top_value_o   = top_q;
  assign stack_depth_o = sp_q;
  assign jump_taken_o  = jt_q;
  assign jump_target_o = jtg_q;
  assign skip_next_o   = skip_q;
  assign out_valid_o   = ov_q;
  assign out_byte_o    = ob_q;
  assign halted_o      = halt_q;
  assign error_code_o  = err_q;

endmodule

[hdl/stack_machine_execute_core_unit.sv]
// Top level of the stack machine execute core.
// One instruction is handled at a time. A result beat is offered once the instruction
// beat is taken (accept in S_IDLE, execute in S_EXEC against the registered stack reads);
// swap and enter pass through S_WR2 for their second stack write, mul waits in S_WAIT on the
// 64x16 partial-product multiplier, and div/mod with a nonzero divisor wait there on the
// one-bit-per-cycle divider. Halted steps and rejected instructions answer in the cycle
// after acceptance. The next instruction is taken in the cycle after the result beat.
// The top of stack is kept in a register; the stack memory has no reset.
module stack_machine_execute_core_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [smec_pkg::SpW-1:0]   cfg_wdata_i,
  smec_in_if.sink                    in_i,
  smec_out_if.source                 out_o
);

  smec_pkg::cmd_t cmd;
  smec_pkg::sts_t sts;

  smec_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  smec_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .opcode_i       (in_i.opcode),
    .immediate_i    (in_i.immediate),
    .next_address_i (in_i.next_address),
    .console_in_i   (in_i.console_in),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .top_value_o    (out_o.top_value),
    .stack_depth_o  (out_o.stack_depth),
    .jump_taken_o   (out_o.jump_taken),
    .jump_target_o  (out_o.jump_target),
    .skip_next_o    (out_o.skip_next),
    .out_valid_o    (out_o.out_valid),
    .out_byte_o     (out_o.out_byte),
    .halted_o       (out_o.halted),
    .error_code_o   (out_o.error_code)
  );

  a_no_accept_while_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !in_i.ready)
    else $error("instruction accepted while a result beat is pending");

  a_depth_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.stack_depth <= smec_pkg::SpW'(smec_pkg::StackDepth))
    else $error("stack depth beyond capacity");

  a_halt_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.halted |=> out_o.halted)
    else $error("halt flag cleared");

  a_jump_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.jump_taken) |->
      (out_o.error_code == smec_pkg::ERR_OK) && !out_o.halted)
    else $error("jump reported with error or halt");

endmodule
